// ----- sv/ttl_cache_with_min_expiry_eviction_defines.svh -----
// Assertion macros used by the answer cache datapath.
// No dependencies; include after the package import is in scope.
`ifndef TTL_CACHE_WITH_MIN_EXPIRY_EVICTION_DEFINES_SVH
`define TTL_CACHE_WITH_MIN_EXPIRY_EVICTION_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TTLC_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TTLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/ttlc_pkg.sv -----
// Types and constants of the answer cache.
// Used by the controller, the datapath and the top level.
package ttlc_pkg;

   localparam int NUM_ENTRIES = 16;
   localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int SLOT_W      = 4;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [63:0] name_key;
      logic [15:0] record_type;
      logic [15:0] record_class;
      logic [31:0] now_seconds;
      logic [30:0] time_to_live;
      logic        has_answer;
      logic [31:0] response_handle;
   } req_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
      logic [31:0]       expiry_time;
      logic [31:0]       handle_out;
      logic              replaced_valid;
      logic              stored;
   } rsp_type;

   // One stored record.
   typedef struct packed {
      logic [63:0] key;
      logic [15:0] rtype;
      logic [15:0] rclass;
      logic [31:0] expiry;
      logic [31:0] handle;
   } ent_rec_type;

   typedef struct packed {
      logic load;
      logic scan_en;
      logic finish;
   } ctrl_type;

   typedef struct packed {
      logic scan_last;
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // Low slot bits of an entry index, for any index width.
   function automatic logic [SLOT_W-1:0] idx_to_slot(input logic [IDX_W-1:0] idx);
      logic [IDX_W+SLOT_W-1:0] wide;
      wide = {{SLOT_W{1'b0}}, idx};
      return wide[SLOT_W-1:0];
   endfunction

endpackage

// ----- sv/ttlc_controller.sv -----
// Sequencer of the answer cache: accept, scan, drain, finish.
// Depends on ttlc_pkg.
module ttlc_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ttlc_pkg::status_type  status,
   output ttlc_pkg::ctrl_type    ctrl
);
   import ttlc_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in     = state_ff;
      ctrl         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               ctrl.load = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctrl.scan_en = 1'b1;
            if (status.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            // last entry is compared here
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            ctrl.finish = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- sv/ttlc_datapath.sv -----
// Record store, scan trackers and response register of the answer cache.
// Depends on ttlc_pkg and the assertion macro header.
`include "ttl_cache_with_min_expiry_eviction_defines.svh"
module ttlc_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  ttlc_pkg::ctrl_type    ctrl,
   output ttlc_pkg::status_type  status,
   input  ttlc_pkg::req_type     req,
   output logic                  rsp_valid,
   output ttlc_pkg::rsp_type     rsp
);
   import ttlc_pkg::*;

   ent_rec_type             mem [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0]  valid_ff, valid_in;

   req_type                 req_ff;
   logic [IDX_W-1:0]        rd_idx_ff, rd_idx_in;
   ent_rec_type             rdata_ff;
   logic                    rvalid_ff;
   logic                    cmp_vld_ff;
   logic [IDX_W-1:0]        cmp_idx_ff;

   logic                    match_found_ff, match_found_in;
   logic [IDX_W-1:0]        match_idx_ff, match_idx_in;
   logic [31:0]             match_exp_ff, match_exp_in;
   logic [31:0]             match_handle_ff, match_handle_in;
   logic                    exp_found_ff, exp_found_in;
   logic [IDX_W-1:0]        exp_idx_ff, exp_idx_in;
   logic [31:0]             min_exp_ff, min_exp_in;
   logic [IDX_W-1:0]        min_idx_ff, min_idx_in;

   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff, rsp_in;

   logic [31:0]             cur_exp;
   logic                    key_eq;
   logic [IDX_W-1:0]        pick;
   logic [32:0]             sum;
   logic [31:0]             expiry_sat;
   logic                    wr_en;
   ent_rec_type             wr_rec;

   // An empty slot reads as expiry zero.
   assign cur_exp = rvalid_ff ? rdata_ff.expiry : 32'd0;
   assign key_eq  = rvalid_ff && (rdata_ff.key == req_ff.name_key)
                    && (rdata_ff.rtype == req_ff.record_type)
                    && (rdata_ff.rclass == req_ff.record_class);

   assign status.scan_last = (rd_idx_ff == IDX_W'(NUM_ENTRIES - 1));

   always_comb begin
      rd_idx_in       = rd_idx_ff;
      match_found_in  = match_found_ff;
      match_idx_in    = match_idx_ff;
      match_exp_in    = match_exp_ff;
      match_handle_in = match_handle_ff;
      exp_found_in    = exp_found_ff;
      exp_idx_in      = exp_idx_ff;
      min_exp_in      = min_exp_ff;
      min_idx_in      = min_idx_ff;
      if (ctrl.load) begin
         rd_idx_in      = '0;
         match_found_in = 1'b0;
         exp_found_in   = 1'b0;
      end else begin
         if (ctrl.scan_en) rd_idx_in = rd_idx_ff + 1'b1;
         if (cmp_vld_ff) begin
            if (!match_found_ff && key_eq) begin
               match_found_in  = 1'b1;
               match_idx_in    = cmp_idx_ff;
               match_exp_in    = rdata_ff.expiry;
               match_handle_in = rdata_ff.handle;
            end
            if (!exp_found_ff && rvalid_ff && (rdata_ff.expiry <= req_ff.now_seconds)) begin
               exp_found_in = 1'b1;
               exp_idx_in   = cmp_idx_ff;
            end
            // strict compare keeps the lowest index on ties
            if ((cmp_idx_ff == '0) || (cur_exp < min_exp_ff)) begin
               min_exp_in = cur_exp;
               min_idx_in = cmp_idx_ff;
            end
         end
      end
   end

   assign pick = match_found_ff ? match_idx_ff : (exp_found_ff ? exp_idx_ff : min_idx_ff);
   assign sum  = {1'b0, req_ff.now_seconds} + {2'b00, req_ff.time_to_live};
   assign expiry_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   assign wr_en = ctrl.finish && (req_ff.cmd == CMD_INSERT) && req_ff.has_answer;

   always_comb begin
      wr_rec.key    = req_ff.name_key;
      wr_rec.rtype  = req_ff.record_type;
      wr_rec.rclass = req_ff.record_class;
      wr_rec.expiry = expiry_sat;
      wr_rec.handle = req_ff.response_handle;
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) valid_in[pick] = 1'b1;
   end

   always_comb begin
      rsp_in = '0;
      if (req_ff.cmd == CMD_LOOKUP) begin
         if (match_found_ff) begin
            rsp_in.hit         = 1'b1;
            rsp_in.slot        = idx_to_slot(match_idx_ff);
            rsp_in.expiry_time = match_exp_ff;
            rsp_in.handle_out  = match_handle_ff;
         end
      end else if (req_ff.has_answer) begin
         rsp_in.slot           = idx_to_slot(pick);
         rsp_in.expiry_time    = expiry_sat;
         rsp_in.handle_out     = req_ff.response_handle;
         rsp_in.replaced_valid = valid_ff[pick];
         rsp_in.stored         = 1'b1;
      end
   end

   // Record memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) mem[pick] <= wr_rec;
      if (ctrl.scan_en) rdata_ff <= mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) req_ff <= req;
      if (ctrl.scan_en) begin
         rvalid_ff  <= valid_ff[rd_idx_ff];
         cmp_idx_ff <= rd_idx_ff;
      end
      if (ctrl.finish) rsp_ff <= rsp_in;
      rd_idx_ff       <= rd_idx_in;
      match_idx_ff    <= match_idx_in;
      match_exp_ff    <= match_exp_in;
      match_handle_ff <= match_handle_in;
      exp_idx_ff      <= exp_idx_in;
      min_exp_ff      <= min_exp_in;
      min_idx_ff      <= min_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         cmp_vld_ff     <= 1'b0;
         match_found_ff <= 1'b0;
         exp_found_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         valid_ff       <= valid_in;
         cmp_vld_ff     <= ctrl.scan_en;
         match_found_ff <= match_found_in;
         exp_found_ff   <= exp_found_in;
         rsp_valid_ff   <= ctrl.finish;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `TTLC_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid_ff, !rsp_valid_ff, "response strobe longer than one cycle")
   `TTLC_ASSERT_NEXT(a_write_sets_valid, clock, reset, wr_en, valid_ff[$past(pick)] && rsp_valid_ff && rsp_ff.stored, "insert did not mark its slot valid")
   `TTLC_ASSERT_IMPLIES(a_hit_not_stored, clock, reset, rsp_valid_ff, !(rsp_ff.hit && (rsp_ff.stored || rsp_ff.replaced_valid)), "lookup and insert flags mixed in one response")

endmodule

// ----- sv/ttl_cache_with_min_expiry_eviction.sv -----
// Top level of the answer cache with minimum-expiry eviction.
// Depends on ttlc_pkg, ttlc_controller and ttlc_datapath.
//
// Usage:
//   Request channel: drive req_data and raise start; the request is taken at
//   the rising edge where start is high and busy is low. busy stays high until
//   the request is finished.
//   Response channel: rsp_valid is high for exactly one cycle with rsp_data;
//   the receiver must take it then, it cannot stall the block.
//   Operation: the request scans the record memory through its single read
//   port, one entry per cycle, then a drain state does the last compare and a
//   finish state picks the slot and writes. The response strobe is registered
//   from the finish state, and busy falls in the same cycle as the strobe. One
//   request is served at a time; the next request may be accepted at the edge
//   that ends the response cycle.
//   Reset (synchronous, active high) clears all valid bits at once and
//   returns the sequencer to idle; no clearing pass is needed.
module ttl_cache_with_min_expiry_eviction (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  ttlc_pkg::req_type  req_data,
   output logic               rsp_valid,
   output ttlc_pkg::rsp_type  rsp_data
);
   import ttlc_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   ttlc_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .ctrl   (ctrl)
   );

   ttlc_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .status    (status),
      .req       (req_data),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

endmodule

// ----- test/ttl_cache_with_min_expiry_eviction_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the TTL answer cache: directed and random lookups and inserts,
// each response checked against a shadow copy of the record table.
// Depends on ttlc_pkg and ttl_cache_with_min_expiry_eviction.
module ttl_cache_with_min_expiry_eviction_test;
   import ttlc_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_ITEMS = 1400;
   localparam int KEY_POOL     = 24;

   typedef struct {
      req_type body;
      bit      settle;   // hold until every outstanding response has come
   } pending_item_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;

   pending_item_type request_q[$];
   rsp_type     awaited_rsp[$];
   int          mismatch_count = 0;
   int          issued_count = 0;
   int          response_count = 0;
   int          cycle_count = 0;
   int          gap_left = 0;

   // Shadow of the record table; valid and expiry start cleared.
   bit          shadow_valid  [NUM_ENTRIES];
   bit [63:0]   shadow_key    [NUM_ENTRIES];
   bit [15:0]   shadow_type   [NUM_ENTRIES];
   bit [15:0]   shadow_class  [NUM_ENTRIES];
   bit [31:0]   shadow_expiry [NUM_ENTRIES];
   bit [31:0]   shadow_handle [NUM_ENTRIES];

   bit [63:0]   pool_key   [KEY_POOL];
   bit [15:0]   pool_type  [KEY_POOL];
   bit [15:0]   pool_class [KEY_POOL];

   ttl_cache_with_min_expiry_eviction dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one request to the shadow table and return the response it should give.
   function automatic rsp_type lookup_or_insert(input req_type r);
      rsp_type     a;
      int          pick;
      logic [32:0] total;
      a = '0;
      pick = -1;
      if (r.cmd == CMD_INSERT && !r.has_answer) begin
         return a;
      end
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (pick < 0 && shadow_valid[i] && shadow_key[i] == r.name_key &&
             shadow_type[i] == r.record_type && shadow_class[i] == r.record_class) begin
            pick = i;
         end
      end
      if (r.cmd == CMD_LOOKUP) begin
         if (pick >= 0) begin
            a.hit         = 1'b1;
            a.slot        = SLOT_W'(pick);
            a.expiry_time = shadow_expiry[pick];
            a.handle_out  = shadow_handle[pick];
         end
         return a;
      end
      // first expired valid entry, else lowest index with the smallest expiry
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (pick < 0 && shadow_valid[i] && shadow_expiry[i] <= r.now_seconds) begin
            pick = i;
         end
      end
      if (pick < 0) begin
         pick = 0;
         for (int i = 1; i < NUM_ENTRIES; i++) begin
            if (shadow_expiry[i] < shadow_expiry[pick]) begin
               pick = i;
            end
         end
      end
      total = {1'b0, r.now_seconds} + {2'b00, r.time_to_live};
      a.replaced_valid = shadow_valid[pick];
      a.slot           = SLOT_W'(pick);
      a.expiry_time    = total[32] ? 32'hFFFF_FFFF : total[31:0];
      a.handle_out     = r.response_handle;
      a.stored         = 1'b1;
      shadow_valid[pick]  = 1'b1;
      shadow_key[pick]    = r.name_key;
      shadow_type[pick]   = r.record_type;
      shadow_class[pick]  = r.record_class;
      shadow_expiry[pick] = a.expiry_time;
      shadow_handle[pick] = r.response_handle;
      return a;
   endfunction

   function automatic req_type make_req(input logic cmd, input logic [63:0] key,
                                        input logic [15:0] rtype, input logic [15:0] rclass,
                                        input logic [31:0] now, input logic [30:0] ttl,
                                        input logic answer, input logic [31:0] handle);
      req_type r;
      r.cmd             = cmd;
      r.name_key        = key;
      r.record_type     = rtype;
      r.record_class    = rclass;
      r.now_seconds     = now;
      r.time_to_live    = ttl;
      r.has_answer      = answer;
      r.response_handle = handle;
      return r;
   endfunction

   task automatic queue_request(input req_type r, input bit settle);
      pending_item_type p;
      p.body   = r;
      p.settle = settle;
      request_q.push_back(p);
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("response %0d: %s got %h, want %h", response_count, field, got, want);
      mismatch_count++;
   endtask

   // Drive requests; idle at random except over a long quiet stretch.
   always @(posedge clock) begin : drive_requests
      bit taken;
      bit quiet;
      taken = start && !busy;
      quiet = issued_count >= 400 && issued_count < 700;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (taken) begin
            awaited_rsp.push_back(lookup_or_insert(req_data));
            issued_count++;
         end
         if (!start || taken) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (request_q.size() == 0 ||
                         (request_q[0].settle && awaited_rsp.size() != 0)) begin
               start <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < 13) begin
               gap_left = $urandom_range(0, 23);
               start <= 1'b0;
            end else begin
               req_data <= request_q[0].body;
               start    <= 1'b1;
               request_q.pop_front();
            end
         end
      end
   end

   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (awaited_rsp.size() == 0) begin
            report_mismatch("response with none awaited", 64'(rsp_data.slot), 64'd0);
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_data.hit !== want.hit)
               report_mismatch("hit", 64'(rsp_data.hit), 64'(want.hit));
            if (rsp_data.slot !== want.slot)
               report_mismatch("slot", 64'(rsp_data.slot), 64'(want.slot));
            if (rsp_data.expiry_time !== want.expiry_time)
               report_mismatch("expiry_time", 64'(rsp_data.expiry_time),
                               64'(want.expiry_time));
            if (rsp_data.handle_out !== want.handle_out)
               report_mismatch("handle_out", 64'(rsp_data.handle_out),
                               64'(want.handle_out));
            if (rsp_data.replaced_valid !== want.replaced_valid)
               report_mismatch("replaced_valid", 64'(rsp_data.replaced_valid),
                               64'(want.replaced_valid));
            if (rsp_data.stored !== want.stored)
               report_mismatch("stored", 64'(rsp_data.stored), 64'(want.stored));
         end
         response_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("ttl_cache_with_min_expiry_eviction_test NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      logic [63:0] key_a;
      logic [63:0] key_b;
      logic [31:0] now_t;
      logic [31:0] now;
      logic [30:0] ttl;
      logic        cmd;
      int          roll;
      int          p;

      key_a = 64'h0123_4567_89AB_CDEF;
      key_b = 64'hFEDC_BA98_7654_3210;

      // Empty table, insert without answer, then hit and near misses on one key.
      queue_request(make_req(CMD_LOOKUP, '1, 16'hFFFF, 16'hFFFF, 32'd5, 31'd0, 1'b1, '1), 1'b0);
      queue_request(make_req(CMD_INSERT, key_a, 16'd1, 16'd1, 32'd100, 31'd50, 1'b0,
                             32'hDEAD_BEEF), 1'b0);
      queue_request(make_req(CMD_INSERT, key_a, 16'd1, 16'd1, 32'd100, 31'd50, 1'b1,
                             32'h1111_0001), 1'b0);
      queue_request(make_req(CMD_LOOKUP, key_a, 16'd1, 16'd1, 32'd120, 31'd0, 1'b0, '0), 1'b0);
      queue_request(make_req(CMD_LOOKUP, key_a, 16'd0, 16'd1, 32'd120, 31'd0, 1'b0, '0), 1'b0);
      queue_request(make_req(CMD_LOOKUP, key_a, 16'd1, 16'd0, 32'd120, 31'd0, 1'b0, '0), 1'b0);
      queue_request(make_req(CMD_LOOKUP, key_a ^ 64'h8000_0000_0000_0000, 16'd1, 16'd1,
                             32'd120, 31'd0, 1'b0, '0), 1'b0);
      // Overwrite of the same key, then expiry saturation.
      queue_request(make_req(CMD_INSERT, key_a, 16'd1, 16'd1, 32'd130, 31'd10, 1'b1,
                             32'h0000_0002), 1'b0);
      queue_request(make_req(CMD_INSERT, key_b, 16'd28, 16'd1, 32'hFFFF_FFF0,
                             31'h7FFF_FFFF, 1'b1, 32'h5555_AAAA), 1'b0);
      queue_request(make_req(CMD_INSERT, '1, '1, '1, '1, '1, 1'b1, '1), 1'b0);
      queue_request(make_req(CMD_INSERT, '0, '0, '0, '0, '0, 1'b1, '0), 1'b0);
      queue_request(make_req(CMD_LOOKUP, '0, '0, '0, '0, '0, 1'b0, '0), 1'b0);
      // Fill the table so later inserts must evict.
      for (int i = 0; i < 12; i++) begin
         queue_request(make_req(CMD_INSERT, key_b + 64'(i + 1), 16'd1, 16'd1, 32'd200,
                                31'(300 + 7 * i), 1'b1, 32'(i)), 1'b0);
      end
      queue_request(make_req(CMD_INSERT, key_a + 64'd99, 16'd5, 16'd3, 32'd400, 31'd5,
                             1'b1, 32'hCAFE_0001), 1'b0);

      // Key pool; some entries share a name but differ in type or class.
      for (int k = 0; k < KEY_POOL; k++) begin
         pool_key[k]   = {$urandom, $urandom};
         pool_type[k]  = 16'($urandom_range(0, 65535));
         pool_class[k] = 16'($urandom_range(0, 65535));
         if (k % 3 == 1) begin
            pool_key[k]  = pool_key[k - 1];
         end
         if (k % 5 == 2) begin
            pool_key[k]  = pool_key[k - 1];
            pool_type[k] = pool_type[k - 1];
         end
      end

      now_t = $urandom_range(0, 1000);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            queue_request(make_req(1'($urandom), {$urandom, $urandom}, 16'($urandom),
                                   16'($urandom), $urandom, 31'($urandom), 1'($urandom),
                                   $urandom), n == 700);
         end else begin
            p     = $urandom_range(0, KEY_POOL - 1);
            now_t = now_t + $urandom_range(0, 6);
            cmd   = ($urandom_range(0, 99) < 45) ? CMD_INSERT : CMD_LOOKUP;
            ttl   = 31'($urandom_range(0, 90));
            now   = (roll < 10) ? 32'hFFFF_FF80 + $urandom_range(0, 127) : now_t;
            queue_request(make_req(cmd, pool_key[p], pool_type[p], pool_class[p], now, ttl,
                                   $urandom_range(0, 19) != 0, $urandom), n == 700);
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (request_q.size() != 0 || start) @(posedge clock);
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (NUM_ENTRIES + 8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("ttl_cache_with_min_expiry_eviction_test OK");
      end else begin
         $display("ttl_cache_with_min_expiry_eviction_test NOT OK");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+sv
sv/ttlc_pkg.sv
sv/ttlc_controller.sv
sv/ttlc_datapath.sv
sv/ttl_cache_with_min_expiry_eviction.sv
test/ttl_cache_with_min_expiry_eviction_test.sv
